FILE: design/bpa_pkg.sv
// shared constants and types of the bitmap page allocator
package bpa_pkg;

  localparam int unsigned MaxPages  = 4096;
  localparam int unsigned PageShift = 12;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned MapDepth  = (MaxPages + WordBits - 1) / WordBits;
  localparam int unsigned MapAw     = $clog2(MapDepth);
  localparam int unsigned BitAw     = $clog2(WordBits);
  localparam int unsigned PageAw    = 12;
  localparam int unsigned LimitW    = 13;
  localparam int unsigned FreeW     = 25;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned ActW      = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned PageBytes = 1 << PageShift;

  localparam logic [CfgIdxW-1:0] CfgEnable    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPageLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMapOffset = 2'd2;

  typedef enum logic [ActW-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_SEED    = 2'd2,
    ACT_RESERVE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_FCHK,
    ST_RMW,
    ST_DONE
  } state_e;

endpackage

FILE: design/bpa_req_if.sv
// request channel of the bitmap page allocator
interface bpa_req_if;
  logic                               valid;
  logic                               ready;
  logic [bpa_pkg::ActW-1:0]           action;
  logic [bpa_pkg::AddrW-1:0]          virt_address;
  logic [bpa_pkg::PageAw-1:0]         page_index;

  modport source (output valid, action, virt_address, page_index, input ready);
  modport sink   (input valid, action, virt_address, page_index, output ready);
endinterface

FILE: design/bpa_rsp_if.sv
// response channel of the bitmap page allocator
interface bpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bpa_pkg::AddrW-1:0]   page_address;
  logic [bpa_pkg::FreeW-1:0]   free_bytes;

  modport source (output valid, ok, page_address, free_bytes, input ready);
  modport sink   (input valid, ok, page_address, free_bytes, output ready);
endinterface

FILE: design/bitmap_page_allocator.sv
// bitmap page allocator top level: used-page bitmap memory and its sequencer
//
// First-fit page allocator over a 64 x 64-bit used-page bitmap held in a
// synchronous RAM with one read port (all pages read as used after reset).
// One item is in work at a time; a finished result sits in an output
// register so the next item can be taken while it waits. Allocate reads one
// bitmap word per cycle from word 0 and stops at the first word with a clear
// bit, or fails once every scanned word is full; an allocate while disabled
// skips the scan and fails. Free first checks the address and rejects a bad
// one without a bitmap access; free, seed and reserve then read, modify and
// write back the addressed bitmap word. An item waits in completion while
// the output register stays full. The user must write the configuration
// registers only while no item is in flight; the block does not enforce it.
module bitmap_page_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bpa_pkg::CfgDataW-1:0]   cfg_wdata_i,
  bpa_req_if.sink                        req_i,
  bpa_rsp_if.source                      rsp_o
);

  localparam int unsigned WordCntW = bpa_pkg::MapAw + 1;

  // configuration
  logic                          enable_q;
  logic [bpa_pkg::LimitW-1:0]    limit_q;
  logic [bpa_pkg::AddrW-1:0]     offset_q;
  logic [bpa_pkg::LimitW-1:0]    eff_limit;
  logic [WordCntW-1:0]           words_cfg;

  // bitmap memory
  logic [bpa_pkg::WordBits-1:0]  mem_q [bpa_pkg::MapDepth];
  logic [bpa_pkg::MapDepth-1:0]  wvalid_q;
  logic                          mem_re;
  logic [bpa_pkg::MapAw-1:0]     mem_ra;
  logic                          mem_we;
  logic [bpa_pkg::MapAw-1:0]     mem_wa;
  logic [bpa_pkg::WordBits-1:0]  mem_wd;
  logic [bpa_pkg::WordBits-1:0]  rd_data_q;
  logic                          rd_valid_q;
  logic [bpa_pkg::WordBits-1:0]  rd_word;

  // sequencer
  bpa_pkg::state_e               state_q, state_d;
  bpa_pkg::action_e              op_q, op_d;
  logic [WordCntW-1:0]           words_q, words_d;
  logic [WordCntW-1:0]           iss_q, iss_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [bpa_pkg::MapAw-1:0]     chk_w_q, chk_w_d;
  logic [bpa_pkg::WordBits-1:0]  fnd_word_q, fnd_word_d;
  logic [bpa_pkg::MapAw-1:0]     fnd_w_q, fnd_w_d;
  logic [bpa_pkg::BitAw-1:0]     fnd_bit;
  logic [bpa_pkg::PageAw-1:0]    fnd_page;
  logic [bpa_pkg::PageAw-1:0]    tgt_page_q, tgt_page_d;
  logic [bpa_pkg::AddrW-1:0]     phys_q, phys_d;
  logic                          vzero_q, vzero_d;
  logic [bpa_pkg::FreeW-1:0]     fc_q, fc_d;
  logic [bpa_pkg::FreeW:0]       fc_sum;
  logic                          res_ok_q, res_ok_d;
  logic [bpa_pkg::AddrW-1:0]     res_addr_q, res_addr_d;
  logic                          tgt_bit;
  logic                          new_bit;
  logic                          free_bad;

  // output register
  logic                          out_vld_q, out_vld_d;
  logic                          out_load;
  logic                          out_ok_q;
  logic [bpa_pkg::AddrW-1:0]     out_addr_q;
  logic [bpa_pkg::FreeW-1:0]     out_fc_q;

  logic                          req_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      limit_q  <= bpa_pkg::LimitW'(bpa_pkg::MaxPages);
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpa_pkg::CfgEnable:    enable_q <= cfg_wdata_i[0];
        bpa_pkg::CfgPageLimit: limit_q  <= cfg_wdata_i[bpa_pkg::LimitW-1:0];
        bpa_pkg::CfgMapOffset: offset_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eff_limit = (limit_q > bpa_pkg::LimitW'(bpa_pkg::MaxPages))
                   ? bpa_pkg::LimitW'(bpa_pkg::MaxPages) : limit_q;
  assign words_cfg = WordCntW'((eff_limit + bpa_pkg::LimitW'(bpa_pkg::WordBits - 1))
                               >> bpa_pkg::BitAw);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  // entries never written read as all used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        wvalid_q[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_q <= wvalid_q[mem_ra];
      end
    end
  end

  assign rd_word = rd_valid_q ? rd_data_q : '1;

  // lowest clear bit of the found word
  always_comb begin
    fnd_bit = '0;
    for (int i = bpa_pkg::WordBits - 1; i >= 0; i--) begin
      if (!fnd_word_q[i]) begin
        fnd_bit = bpa_pkg::BitAw'(i);
      end
    end
  end

  assign fnd_page = {fnd_w_q, fnd_bit};
  assign tgt_bit  = rd_word[tgt_page_q[bpa_pkg::BitAw-1:0]];
  assign new_bit  = (op_q == bpa_pkg::ACT_RESERVE);
  assign fc_sum   = {1'b0, fc_q} + (bpa_pkg::FreeW + 1)'(bpa_pkg::PageBytes);
  assign free_bad = !enable_q || vzero_q
                 || (phys_q[bpa_pkg::PageShift-1:0] != '0)
                 || (phys_q[bpa_pkg::AddrW-1:bpa_pkg::PageShift+bpa_pkg::PageAw] != '0)
                 || ({1'b0, phys_q[bpa_pkg::PageShift+bpa_pkg::PageAw-1:bpa_pkg::PageShift]}
                     >= eff_limit);

  assign req_i.ready = (state_q == bpa_pkg::ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_load    = (state_q == bpa_pkg::ST_DONE) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    words_d    = words_q;
    iss_d      = iss_q;
    chk_vld_d  = 1'b0;
    chk_w_d    = chk_w_q;
    fnd_word_d = fnd_word_q;
    fnd_w_d    = fnd_w_q;
    tgt_page_d = tgt_page_q;
    phys_d     = phys_q;
    vzero_d    = vzero_q;
    fc_d       = fc_q;
    res_ok_d   = res_ok_q;
    res_addr_d = res_addr_q;
    mem_re     = 1'b0;
    mem_ra     = '0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    case (state_q)
      bpa_pkg::ST_IDLE: begin
        if (req_acc) begin
          op_d       = bpa_pkg::action_e'(req_i.action);
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          tgt_page_d = req_i.page_index;
          phys_d     = req_i.virt_address - offset_q;
          vzero_d    = (req_i.virt_address == '0);
          words_d    = words_cfg;
          iss_d      = '0;
          case (bpa_pkg::action_e'(req_i.action))
            bpa_pkg::ACT_ALLOC: begin
              state_d = (enable_q && words_cfg != '0) ? bpa_pkg::ST_SCAN : bpa_pkg::ST_DONE;
            end
            bpa_pkg::ACT_FREE: begin
              state_d = bpa_pkg::ST_FCHK;
            end
            default: begin
              mem_re  = 1'b1;
              mem_ra  = req_i.page_index[bpa_pkg::PageAw-1:bpa_pkg::BitAw];
              state_d = bpa_pkg::ST_RMW;
            end
          endcase
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (iss_q < words_q) begin
          mem_re    = 1'b1;
          mem_ra    = iss_q[bpa_pkg::MapAw-1:0];
          iss_d     = iss_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_w_d   = iss_q[bpa_pkg::MapAw-1:0];
        end
        if (chk_vld_q) begin
          if (rd_word != '1) begin
            fnd_word_d = rd_word;
            fnd_w_d    = chk_w_q;
            chk_vld_d  = 1'b0;
            state_d    = bpa_pkg::ST_FIND;
          end else if ({1'b0, chk_w_q} == words_q - 1'b1) begin
            chk_vld_d = 1'b0;
            state_d   = bpa_pkg::ST_DONE;
          end
        end
      end
      bpa_pkg::ST_FIND: begin
        state_d = bpa_pkg::ST_DONE;
        if ({1'b0, fnd_page} < eff_limit) begin
          mem_we     = 1'b1;
          mem_wa     = fnd_w_q;
          mem_wd     = fnd_word_q | (bpa_pkg::WordBits'(1) << fnd_bit);
          res_ok_d   = 1'b1;
          res_addr_d = (bpa_pkg::AddrW'(fnd_page) << bpa_pkg::PageShift) + offset_q;
          if (fc_q >= bpa_pkg::FreeW'(bpa_pkg::PageBytes)) begin
            fc_d = fc_q - bpa_pkg::FreeW'(bpa_pkg::PageBytes);
          end
        end
      end
      bpa_pkg::ST_FCHK: begin
        tgt_page_d = phys_q[bpa_pkg::PageShift+bpa_pkg::PageAw-1:bpa_pkg::PageShift];
        if (free_bad) begin
          state_d = bpa_pkg::ST_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = phys_q[bpa_pkg::PageShift+bpa_pkg::PageAw-1:
                           bpa_pkg::PageShift+bpa_pkg::BitAw];
          state_d = bpa_pkg::ST_RMW;
        end
      end
      bpa_pkg::ST_RMW: begin
        state_d = bpa_pkg::ST_DONE;
        if (tgt_bit != new_bit) begin
          mem_we   = 1'b1;
          mem_wa   = tgt_page_q[bpa_pkg::PageAw-1:bpa_pkg::BitAw];
          res_ok_d = 1'b1;
          if (new_bit) begin
            mem_wd = rd_word | (bpa_pkg::WordBits'(1) << tgt_page_q[bpa_pkg::BitAw-1:0]);
          end else begin
            mem_wd = rd_word & ~(bpa_pkg::WordBits'(1) << tgt_page_q[bpa_pkg::BitAw-1:0]);
          end
          if (op_q == bpa_pkg::ACT_FREE) begin
            fc_d = fc_sum[bpa_pkg::FreeW] ? '1 : fc_sum[bpa_pkg::FreeW-1:0];
          end
        end
      end
      bpa_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpa_pkg::ST_IDLE;
      chk_vld_q <= 1'b0;
      fc_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      fc_q      <= fc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    words_q    <= words_d;
    iss_q      <= iss_d;
    chk_w_q    <= chk_w_d;
    fnd_word_q <= fnd_word_d;
    fnd_w_q    <= fnd_w_d;
    tgt_page_q <= tgt_page_d;
    phys_q     <= phys_d;
    vzero_q    <= vzero_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    if (out_load) begin
      out_ok_q   <= res_ok_q;
      out_addr_q <= res_addr_q;
      out_fc_q   <= fc_q;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.ok           = out_ok_q;
  assign rsp_o.page_address = out_addr_q;
  assign rsp_o.free_bytes   = out_fc_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("request taken while previous item still in work");

  a_no_read_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("bitmap read and write in the same cycle");

  a_scan_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpa_pkg::ST_SCAN || state_q == bpa_pkg::ST_FIND) |-> enable_q)
    else $error("allocation scan running while disabled");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == bpa_pkg::ST_DONE))
    else $error("result presented outside completion");
`endif

endmodule
